// ----- rtl/core/skid_steer_pose_integrator_assert.svh -----
// Assertion macros used by the checker file of the pose integrator.
`ifndef SKID_STEER_POSE_INTEGRATOR_ASSERT_SVH
`define SKID_STEER_POSE_INTEGRATOR_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define SSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pose integrator check failed");

// Condition that must never hold outside reset.
`define SSP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pose integrator check failed");

`endif

// ----- rtl/core/ssp_pkg.sv -----
// Types, constants and helper functions of the pose integrator.
`timescale 1ns / 1ps
package ssp_pkg;

	localparam int ROTATION_STAGES = 14;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_STAGES = (ROTATION_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
		: ROTATION_STAGES;
	localparam int FRONT_STAGES = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW = 3;
	localparam int ITEM_LATENCY = FRONT_STAGES + 2 + CORDIC_STAGES + 4;

	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032875;
	localparam logic signed [17:0] PI_Q12 = 18'sd12868;
	localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
	localparam logic signed [17:0] FOUR_PI_Q12 = 18'sd51472;

	localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525158,
		32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
		32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
		32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128
	};

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_FORWARD_GAIN   = 3'd0,
		REG_YAW_GAIN       = 3'd1,
		REG_GRADE_GAIN     = 3'd2,
		REG_ICR_OFFSET     = 3'd3,
		REG_SIDE_SLIP_GAIN = 3'd4
	} ssp_reg_t;

	typedef struct packed {
		logic signed [15:0] forward_gain;
		logic signed [15:0] yaw_gain;
		logic signed [15:0] grade_gain;
		logic signed [15:0] icr_offset;
		logic signed [15:0] side_slip_gain;
	} ssp_cfg_t;

	// Pose and body twist handed from the front to the back.
	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [14:0] yaw;
		logic [15:0]        dt;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] wr;
	} ssp_twist_t;

	// Queue status seen by the top level and the back.
	typedef struct packed {
		logic empty;
		logic busy;
	} ssp_qstat_t;

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		logic signed [15:0] r;
		if (v > 40'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -40'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -40'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ssp_front.sv -----
// Front of the pose integrator: accepts items and forms the body twist.
`timescale 1ns / 1ps
module ssp_front import ssp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ssp_cfg_t           cfg,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [14:0] pose_yaw,
	input  logic signed [15:0] speed_command,
	input  logic signed [15:0] turn_command,
	input  logic [15:0]        time_step,
	input  logic signed [15:0] grade_along,
	input  logic signed [15:0] grade_across,
	output logic               out_valid,
	output ssp_twist_t         out_twist
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] px_s1, px_s2, px_s3;
	logic signed [31:0] py_s1, py_s2, py_s3;
	logic signed [14:0] yaw_s1, yaw_s2, yaw_s3;
	logic [15:0]        dt_s1, dt_s2, dt_s3;
	logic signed [15:0] gac_s1, gac_s2;
	logic signed [31:0] p_grade_s1, p_fwd_s1, p_yaw_s1, p_fwd_s2;
	logic [17:0]        factor_s2;
	logic signed [15:0] wr_s2, wr_s3;
	logic signed [50:0] m_s3;
	logic signed [31:0] a_s3, b_s3;
	ssp_twist_t         tw_s4;

	logic [14:0]        uphill;
	logic signed [32:0] t_grade, t_yaw;
	logic signed [18:0] r_grade;
	logic signed [19:0] factor_full;
	logic signed [50:0] t_fwd;
	logic signed [34:0] t_lat;

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Only an uphill gradient slows the vehicle.
	assign uphill = grade_along[15] ? 15'd0 : grade_along[14:0];

	// Stage two arithmetic: uphill factor and saturated yaw rate.
	always_comb begin
		t_grade = {p_grade_s1[31], p_grade_s1} + 33'sd8192;
		r_grade = $signed(t_grade[32:14]);
		factor_full = 20'sd4096 - {r_grade[18], r_grade};
		t_yaw = {p_yaw_s1[31], p_yaw_s1} + 33'sd2048;
	end

	// Stage four arithmetic: forward and lateral speed.
	always_comb begin
		t_fwd = m_s3 + 51'sd8388608;
		t_lat = 35'sd0 - $signed({a_s3[31], a_s3, 2'b00})
			- $signed({{3{b_s3[31]}}, b_s3}) + 35'sd8192;
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		px_s1 <= pose_x;
		py_s1 <= pose_y;
		yaw_s1 <= pose_yaw;
		dt_s1 <= time_step;
		gac_s1 <= grade_across;
		p_grade_s1 <= cfg.grade_gain * $signed({1'b0, uphill});
		p_fwd_s1 <= cfg.forward_gain * speed_command;
		p_yaw_s1 <= cfg.yaw_gain * turn_command;

		px_s2 <= px_s1;
		py_s2 <= py_s1;
		yaw_s2 <= yaw_s1;
		dt_s2 <= dt_s1;
		gac_s2 <= gac_s1;
		p_fwd_s2 <= p_fwd_s1;
		factor_s2 <= factor_full[19] ? 18'd0 : factor_full[17:0];
		wr_s2 <= sat16({{19{t_yaw[32]}}, t_yaw[32:12]});

		px_s3 <= px_s2;
		py_s3 <= py_s2;
		yaw_s3 <= yaw_s2;
		dt_s3 <= dt_s2;
		wr_s3 <= wr_s2;
		m_s3 <= p_fwd_s2 * $signed({1'b0, factor_s2});
		a_s3 <= cfg.icr_offset * wr_s2;
		b_s3 <= cfg.side_slip_gain * gac_s2;

		tw_s4.pose_x <= px_s3;
		tw_s4.pose_y <= py_s3;
		tw_s4.yaw <= yaw_s3;
		tw_s4.dt <= dt_s3;
		tw_s4.wr <= wr_s3;
		tw_s4.vx <= sat16({{13{t_fwd[50]}}, t_fwd[50:24]});
		tw_s4.vy <= sat16({{19{t_lat[34]}}, t_lat[34:14]});
	end

	assign out_valid = v_s4;
	assign out_twist = tw_s4;

endmodule

// ----- rtl/core/ssp_queue.sv -----
// Short queue between the front and the back of the pose integrator.
`timescale 1ns / 1ps
module ssp_queue import ssp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ssp_twist_t push_data,
	input  logic       pop,
	output ssp_twist_t head_data,
	output ssp_qstat_t status
);

	ssp_twist_t        mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_pop;

	assign do_pop = pop && (count_q != '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	assign head_data = mem[rd_ptr_q];

	// Refuse new items while the items in the front could overfill the queue.
	assign status.empty = (count_q == '0);
	assign status.busy = (count_q >= (QUEUE_AW+1)'(QUEUE_DEPTH - FRONT_STAGES));

endmodule

// ----- rtl/core/ssp_back.sv -----
// Back of the pose integrator: CORDIC rotation, integration and heading wrap.
`timescale 1ns / 1ps
module ssp_back import ssp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ssp_qstat_t         qstat,
	input  ssp_twist_t         in_twist,
	output logic               pop,
	output logic               done,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [14:0] next_heading,
	output logic signed [15:0] body_forward_speed,
	output logic signed [15:0] body_lateral_speed,
	output logic signed [15:0] body_yaw_rate
);

	logic               vld_s [CORDIC_STAGES+1];
	logic signed [33:0] cx_s [CORDIC_STAGES+1];
	logic signed [33:0] cy_s [CORDIC_STAGES+1];
	logic signed [35:0] cz_s [CORDIC_STAGES+1];
	logic               neg_s [CORDIC_STAGES+1];
	ssp_twist_t         tw_s [CORDIC_STAGES+1];

	logic signed [35:0] z_in;

	logic               v_c1, v_c2, v_c3, v_c4;
	ssp_twist_t         tw_c1, tw_c2, tw_c3;
	logic signed [49:0] cvx_c1, svy_c1, svx_c1, cvy_c1;
	logic signed [32:0] whd_c1;
	logic signed [36:0] wx_c2, wy_c2;
	logic signed [14:0] hd_c2, hd_c3;
	logic signed [53:0] mx_c3, my_c3;
	logic signed [31:0] nx_c4, ny_c4;
	logic signed [14:0] hd_c4;
	logic signed [15:0] vx_c4, vy_c4, wr_c4;

	logic signed [33:0] c_val, s_val;
	logic signed [50:0] sum_x, sum_y;
	logic signed [32:0] t_hd;
	logic signed [17:0] h_raw;
	logic signed [17:0] h_wrap;
	logic signed [54:0] t_mx, t_my;

	assign pop = !qstat.empty;

	// Valid bits of the rotation stages and of the integration stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
			v_c4 <= 1'b0;
		end else begin
			vld_s[0] <= !qstat.empty;
			v_c1 <= vld_s[CORDIC_STAGES];
			v_c2 <= v_c1;
			v_c3 <= v_c2;
			v_c4 <= v_c3;
		end
	end

	// Range reduction into [-pi/2, pi/2], remembering the sign flip.
	assign z_in = {{3{in_twist.yaw[14]}}, in_twist.yaw, 18'd0};

	always_ff @(posedge clk) begin
		tw_s[0] <= in_twist;
		cx_s[0] <= CORDIC_INV_GAIN;
		cy_s[0] <= 34'sd0;
		if (z_in > HALF_PI_Q30) begin
			cz_s[0] <= z_in - PI_Q30;
			neg_s[0] <= 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			cz_s[0] <= z_in + PI_Q30;
			neg_s[0] <= 1'b1;
		end else begin
			cz_s[0] <= z_in;
			neg_s[0] <= 1'b0;
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		logic signed [35:0] atan_i;
		assign atan_i = $signed({4'd0, ATAN_Q30[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			tw_s[i+1] <= tw_s[i];
			neg_s[i+1] <= neg_s[i];
			if (!cz_s[i][35]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - atan_i;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + atan_i;
			end
		end
	end

	// Cosine and sine with the folded sign restored.
	always_comb begin
		c_val = neg_s[CORDIC_STAGES] ? -cx_s[CORDIC_STAGES] : cx_s[CORDIC_STAGES];
		s_val = neg_s[CORDIC_STAGES] ? -cy_s[CORDIC_STAGES] : cy_s[CORDIC_STAGES];
	end

	// World velocity, heading step and wrap.
	always_comb begin
		sum_x = {cvx_c1[49], cvx_c1} - {svy_c1[49], svy_c1} + 51'sd8192;
		sum_y = {svx_c1[49], svx_c1} + {cvy_c1[49], cvy_c1} + 51'sd8192;
		t_hd = whd_c1 + 33'sd32768;
		h_raw = {{3{tw_c1.yaw[14]}}, tw_c1.yaw} + {t_hd[32], t_hd[32:16]};
		if (h_raw >= PI_Q12 + TWO_PI_Q12) begin
			h_wrap = h_raw - FOUR_PI_Q12;
		end else if (h_raw >= PI_Q12) begin
			h_wrap = h_raw - TWO_PI_Q12;
		end else if (h_raw < -PI_Q12 - TWO_PI_Q12) begin
			h_wrap = h_raw + FOUR_PI_Q12;
		end else if (h_raw < -PI_Q12) begin
			h_wrap = h_raw + TWO_PI_Q12;
		end else begin
			h_wrap = h_raw;
		end
		t_mx = {mx_c3[53], mx_c3} + 55'sd134217728;
		t_my = {my_c3[53], my_c3} + 55'sd134217728;
	end

	// Integration stages.
	always_ff @(posedge clk) begin
		tw_c1 <= tw_s[CORDIC_STAGES];
		cvx_c1 <= c_val * tw_s[CORDIC_STAGES].vx;
		svy_c1 <= s_val * tw_s[CORDIC_STAGES].vy;
		svx_c1 <= s_val * tw_s[CORDIC_STAGES].vx;
		cvy_c1 <= c_val * tw_s[CORDIC_STAGES].vy;
		whd_c1 <= tw_s[CORDIC_STAGES].wr * $signed({1'b0, tw_s[CORDIC_STAGES].dt});

		tw_c2 <= tw_c1;
		wx_c2 <= $signed(sum_x[50:14]);
		wy_c2 <= $signed(sum_y[50:14]);
		hd_c2 <= h_wrap[14:0];

		tw_c3 <= tw_c2;
		hd_c3 <= hd_c2;
		mx_c3 <= wx_c2 * $signed({1'b0, tw_c2.dt});
		my_c3 <= wy_c2 * $signed({1'b0, tw_c2.dt});

		nx_c4 <= sat32({{8{tw_c3.pose_x[31]}}, tw_c3.pose_x}
			+ {{13{t_mx[54]}}, t_mx[54:28]});
		ny_c4 <= sat32({{8{tw_c3.pose_y[31]}}, tw_c3.pose_y}
			+ {{13{t_my[54]}}, t_my[54:28]});
		hd_c4 <= hd_c3;
		vx_c4 <= tw_c3.vx;
		vy_c4 <= tw_c3.vy;
		wr_c4 <= tw_c3.wr;
	end

	assign done = v_c4;
	assign next_x = nx_c4;
	assign next_y = ny_c4;
	assign next_heading = hd_c4;
	assign body_forward_speed = vx_c4;
	assign body_lateral_speed = vy_c4;
	assign body_yaw_rate = wr_c4;

endmodule

// ----- rtl/core/skid_steer_pose_integrator.sv -----
// Top level of the skid-steer pose integrator.
//
//   Channel   Handshake          Payload
//   input     start / busy       pose_x, pose_y, pose_yaw, speed_command, turn_command,
//                                time_step, grade_along, grade_across
//   result    done (one cycle)   next_x, next_y, next_heading, body_forward_speed,
//                                body_lateral_speed, body_yaw_rate
//   config    cfg_we             cfg_index, cfg_data
//
// One item is taken each cycle while busy is low; a result passes through the four twist
// stages, the queue, the range reduction, the 14 CORDIC stages and the four integration
// stages before it is transferred.
// Reset clears the valid bits and the queue and sets the gain registers to their defaults; no clearing pass.
// Results cannot be held off, so the back never stalls and busy stays low in use.
`timescale 1ns / 1ps
module skid_steer_pose_integrator import ssp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [14:0] pose_yaw,
	input  logic signed [15:0] speed_command,
	input  logic signed [15:0] turn_command,
	input  logic [15:0]        time_step,
	input  logic signed [15:0] grade_along,
	input  logic signed [15:0] grade_across,
	output logic               done,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [14:0] next_heading,
	output logic signed [15:0] body_forward_speed,
	output logic signed [15:0] body_lateral_speed,
	output logic signed [15:0] body_yaw_rate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	ssp_cfg_t   cfg_q;
	ssp_qstat_t qstat;
	ssp_twist_t front_twist, head_twist;
	logic       front_valid, back_pop, accept;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forward_gain <= 16'sd4096;
			cfg_q.yaw_gain <= 16'sd4096;
			cfg_q.grade_gain <= 16'sd0;
			cfg_q.icr_offset <= 16'sd0;
			cfg_q.side_slip_gain <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORWARD_GAIN:   cfg_q.forward_gain <= cfg_data;
				REG_YAW_GAIN:       cfg_q.yaw_gain <= cfg_data;
				REG_GRADE_GAIN:     cfg_q.grade_gain <= cfg_data;
				REG_ICR_OFFSET:     cfg_q.icr_offset <= cfg_data;
				REG_SIDE_SLIP_GAIN: cfg_q.side_slip_gain <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = qstat.busy;
	assign accept = start && !qstat.busy;

	ssp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept),
		.cfg           (cfg_q),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.pose_yaw      (pose_yaw),
		.speed_command (speed_command),
		.turn_command  (turn_command),
		.time_step     (time_step),
		.grade_along   (grade_along),
		.grade_across  (grade_across),
		.out_valid     (front_valid),
		.out_twist     (front_twist)
	);

	ssp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_twist),
		.pop       (back_pop),
		.head_data (head_twist),
		.status    (qstat)
	);

	ssp_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.qstat              (qstat),
		.in_twist           (head_twist),
		.pop                (back_pop),
		.done               (done),
		.next_x             (next_x),
		.next_y             (next_y),
		.next_heading       (next_heading),
		.body_forward_speed (body_forward_speed),
		.body_lateral_speed (body_lateral_speed),
		.body_yaw_rate      (body_yaw_rate)
	);

endmodule

// ----- rtl/core/ssp_checker.sv -----
// Port-level checks of the pose integrator and their bind.
`timescale 1ns / 1ps
`include "skid_steer_pose_integrator_assert.svh"
module ssp_checker import ssp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [14:0] next_heading
);

	// Every result follows its transfer after a fixed latency, and vice versa.
	`SSP_ASSERT_IMPLIES(a_done_has_item, clk, arst_n, done, $past(start && !busy, ITEM_LATENCY))
	`SSP_ASSERT_IMPLIES(a_item_gives_done, clk, arst_n, start && !busy, ##ITEM_LATENCY done)
	// The heading leaves the wrap stage inside [-pi, pi).
	`SSP_ASSERT_IMPLIES(a_heading_wrapped, clk, arst_n, done,
		next_heading >= -15'sd12868 && next_heading <= 15'sd12867)
	// The back never stalls, so the queue never pushes back on the input.
	`SSP_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

endmodule

bind skid_steer_pose_integrator ssp_checker u_ssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.next_heading (next_heading)
);

// ----- verif/skid_steer_pose_integrator_tb.sv -----
// Self-checking testbench of the skid-steer pose integrator.
`timescale 1ns / 1ps
module skid_steer_pose_integrator_tb;
	import ssp_pkg::*;

	localparam int  RANDOM_ITEMS = 1250;
	localparam int  PHASES       = 10;
	localparam int  CYCLE_LIMIT  = 500000;
	localparam int  SETTLE       = ITEM_LATENCY + 8;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [14:0] yaw;
		logic signed [15:0] speed;
		logic signed [15:0] turn;
		logic [15:0]        dt;
		logic signed [15:0] along;
		logic signed [15:0] across;
	} pose_in_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [14:0] heading;
		logic signed [15:0] fwd;
		logic signed [15:0] lat;
		logic signed [15:0] rate;
	} pose_res_t;

	typedef struct packed {
		pose_in_t  stim;
		logic      typed;
		pose_res_t res;
	} step_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] pose_x = '0;
	logic signed [31:0] pose_y = '0;
	logic signed [14:0] pose_yaw = '0;
	logic signed [15:0] speed_command = '0;
	logic signed [15:0] turn_command = '0;
	logic [15:0]        time_step = '0;
	logic signed [15:0] grade_along = '0;
	logic signed [15:0] grade_across = '0;
	logic               done;
	logic signed [31:0] next_x;
	logic signed [31:0] next_y;
	logic signed [14:0] next_heading;
	logic signed [15:0] body_forward_speed;
	logic signed [15:0] body_lateral_speed;
	logic signed [15:0] body_yaw_rate;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// Local copy of the gain registers.
	logic signed [15:0] gain_fwd, gain_yaw, gain_grade, icr_off, gain_slip;

	pose_res_t pending_poses[$];
	int        fail_count = 0;
	int        cycle_count = 0;

	skid_steer_pose_integrator DUT (.*);

	always #4 clk = ~clk;

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// Twist, rotation and integration of one pose update.
	function automatic pose_res_t integrate_pose(pose_in_t p);
		longint fg, yg, gg, icr, ssg, uphill, factor, vx, vy, wr;
		longint z, cx, sy, nxt, c, s, wx, wy, hd;
		bit flip;
		pose_res_t r;
		fg = gain_fwd; yg = gain_yaw; gg = gain_grade; icr = icr_off; ssg = gain_slip;
		uphill = p.along > 0 ? longint'(p.along) : 0;
		factor = 4096 - round_shift(gg * uphill, 14);
		if (factor < 0) factor = 0;
		vx = clamp(round_shift(fg * longint'(p.speed) * factor, 24), 16);
		wr = clamp(round_shift(yg * longint'(p.turn), 12), 16);
		vy = clamp(round_shift(-4 * icr * wr - ssg * longint'(p.across), 14), 16);
		// Fold the heading into the right half plane, then rotate.
		z = longint'(p.yaw) * 262144;
		flip = 1'b0;
		if (z > longint'(HALF_PI_Q30)) begin
			z -= longint'(PI_Q30);
			flip = 1'b1;
		end else if (z < -longint'(HALF_PI_Q30)) begin
			z += longint'(PI_Q30);
			flip = 1'b1;
		end
		cx = longint'(CORDIC_INV_GAIN);
		sy = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (z >= 0) begin
				nxt = cx - (sy >>> i);
				sy = sy + (cx >>> i);
				z -= longint'(ATAN_Q30[i]);
			end else begin
				nxt = cx + (sy >>> i);
				sy = sy - (cx >>> i);
				z += longint'(ATAN_Q30[i]);
			end
			cx = nxt;
		end
		c = flip ? -cx : cx;
		s = flip ? -sy : sy;
		wx = round_shift(c * vx - s * vy, 14);
		wy = round_shift(s * vx + c * vy, 14);
		r.x = 32'(clamp(longint'(p.x) + round_shift(wx * longint'(p.dt), 28), 32));
		r.y = 32'(clamp(longint'(p.y) + round_shift(wy * longint'(p.dt), 28), 32));
		hd = longint'(p.yaw) + round_shift(wr * longint'(p.dt), 16);
		while (hd >= longint'(PI_Q12)) hd -= longint'(TWO_PI_Q12);
		while (hd < -longint'(PI_Q12)) hd += longint'(TWO_PI_Q12);
		r.heading = 15'(hd);
		r.fwd = 16'(vx);
		r.lat = 16'(vy);
		r.rate = 16'(wr);
		return r;
	endfunction

	// Random field value biased towards the extremes and zero.
	function automatic logic [31:0] pick_field(int w, bit sgn);
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = sgn ? (32'h1 << (w - 1)) - 1 : (32'h1 << w) - 1;
			1: v = sgn ? (32'h1 << (w - 1)) : 32'h0;
			2: v = 32'h0;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic pose_in_t random_pose();
		pose_in_t p;
		p.x = pick_field(32, 1'b1);
		p.y = pick_field(32, 1'b1);
		p.yaw = 15'(pick_field(15, 1'b1));
		p.speed = 16'(pick_field(16, 1'b1));
		p.turn = 16'(pick_field(16, 1'b1));
		p.dt = 16'(pick_field(16, 1'b0));
		p.along = 16'(pick_field(16, 1'b1));
		p.across = 16'(pick_field(16, 1'b1));
		return p;
	endfunction

	function automatic int random_gap();
		int k;
		k = $urandom_range(99);
		return k < 65 ? 0 : (k < 93 ? $urandom_range(3, 1) : $urandom_range(40, 10));
	endfunction

	// One input transfer; the expectation is queued at the accepting edge.
	task automatic send_pose(pose_in_t p, bit typed, pose_res_t res, int gap);
		start <= 1'b1;
		pose_x <= p.x; pose_y <= p.y; pose_yaw <= p.yaw;
		speed_command <= p.speed; turn_command <= p.turn; time_step <= p.dt;
		grade_along <= p.along; grade_across <= p.across;
		do @(posedge clk); while (busy);
		pending_poses.push_back(typed ? res : integrate_pose(p));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write while the block is idle.
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_FORWARD_GAIN:   gain_fwd = val;
			REG_YAW_GAIN:       gain_yaw = val;
			REG_GRADE_GAIN:     gain_grade = val;
			REG_ICR_OFFSET:     icr_off = val;
			REG_SIDE_SLIP_GAIN: gain_slip = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		pose_res_t e;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_poses.size() == 0) begin
				$error("result transfer with no pose update pending");
				fail_count++;
			end else begin
				e = pending_poses.pop_front();
				if (next_x !== e.x) begin
					$error("next_x expected %0d got %0d", e.x, next_x); fail_count++;
				end
				if (next_y !== e.y) begin
					$error("next_y expected %0d got %0d", e.y, next_y); fail_count++;
				end
				if (next_heading !== e.heading) begin
					$error("next_heading expected %0d got %0d", e.heading, next_heading);
					fail_count++;
				end
				if (body_forward_speed !== e.fwd) begin
					$error("body_forward_speed expected %0d got %0d", e.fwd,
						body_forward_speed);
					fail_count++;
				end
				if (body_lateral_speed !== e.lat) begin
					$error("body_lateral_speed expected %0d got %0d", e.lat,
						body_lateral_speed);
					fail_count++;
				end
				if (body_yaw_rate !== e.rate) begin
					$error("body_yaw_rate expected %0d got %0d", e.rate, body_yaw_rate);
					fail_count++;
				end
			end
		end
	end

	initial begin
		step_row_t rows [15];
		logic [15:0] vals [5];
		pose_res_t none;
		none = '0;
		gain_fwd = 16'sd4096; gain_yaw = 16'sd4096;
		gain_grade = '0; icr_off = '0; gain_slip = '0;
		// Directed rows: x, y, yaw, speed, turn, dt, along, across.
		rows = '{
			'{'{32'sd0, 32'sd0, 15'sd0, 16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0}, 1'b1,
				'{32'sd0, 32'sd0, 15'sd0, 16'sd0, 16'sd0, 16'sd0}},
			'{'{32'sh7FFFFFFF, 32'sh80000000, 15'sd0, 16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0},
				1'b1, '{32'sh7FFFFFFF, 32'sh80000000, 15'sd0, 16'sd0, 16'sd0, 16'sd0}},
			'{'{32'sh80000000, 32'sh7FFFFFFF, 15'sd0, 16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0},
				1'b1, '{32'sh80000000, 32'sh7FFFFFFF, 15'sd0, 16'sd0, 16'sd0, 16'sd0}},
			'{'{32'sd0, 32'sd0, 15'sd0, 16'sd32767, 16'sd0, 16'd65535, 16'sd0, 16'sd0},
				1'b0, none},
			'{'{32'sd0, 32'sd0, 15'sd12868, -16'sd32768, 16'sd32767, 16'd65535, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd0, 32'sd0, -15'sd12868, 16'sd4096, -16'sd32768, 16'd65535, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd100, 32'sd0, 15'sd16383, 16'sd20000, 16'sd0, 16'd40000, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd0, 32'sd100, -15'sd16384, 16'sd20000, 16'sd0, 16'd40000, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd0, 32'sd0, 15'sd6434, 16'sd4096, 16'sd0, 16'd65535, 16'sd0, 16'sd0},
				1'b0, none},
			'{'{32'sd0, 32'sd0, -15'sd6434, 16'sd4096, 16'sd0, 16'd65535, 16'sd0, 16'sd0},
				1'b0, none},
			'{'{32'sd0, 32'sd0, 15'sd1000, 16'sd8192, 16'sd0, 16'd1000, 16'sd32767,
				-16'sd32768}, 1'b0, none},
			'{'{32'sd0, 32'sd0, 15'sd1000, 16'sd8192, 16'sd0, 16'd1000, -16'sd32768,
				16'sd32767}, 1'b0, none},
			'{'{32'sh7FFFFF00, 32'sd0, 15'sd0, 16'sd32767, 16'sd0, 16'd65535, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd0, 32'sh80000100, -15'sd6434, 16'sd32767, 16'sd0, 16'd65535, 16'sd0,
				16'sd0}, 1'b0, none},
			'{'{32'sd0, 32'sd0, 15'sd12867, 16'sd0, 16'sd32767, 16'd65535, 16'sd0, 16'sd0},
				1'b0, none}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_pose(rows[i].stim, rows[i].typed, rows[i].res, random_gap());
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: vals = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
				1: vals = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
				2: vals = '{16'd4096, 16'd4096, 16'd0, 16'd0, 16'd0};
				3: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				4: vals = '{16'd3900, 16'd4300, 16'd2000, 16'd400, 16'd800};
				default: foreach (vals[k]) vals[k] = 16'($urandom);
			endcase
			for (int k = 0; k < 5; k++) write_reg(3'(k), vals[k]);
			// Writes beyond the last register must be ignored.
			write_reg(3'($urandom_range(7, 5)), 16'($urandom));
			cfg_we <= 1'b0;
			@(posedge clk);
			repeat (RANDOM_ITEMS / PHASES)
				send_pose(random_pose(), 1'b0, none,
					($urandom_range(3) == 0) ? 0 : random_gap());
			drain();
		end

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
